FILE: design/vla_pkg.sv
package vla_pkg;

    // Grid geometry
    localparam int GRID_X      = 16;
    localparam int GRID_Y      = 16;
    localparam int GRID_Z      = 16;
    localparam int XW          = $clog2(GRID_X);
    localparam int YW          = $clog2(GRID_Y);
    localparam int ZW          = $clog2(GRID_Z);
    localparam int LAYER_CELLS = GRID_X * GRID_Y;
    localparam int LAYER_AW    = $clog2(LAYER_CELLS);
    localparam int MEM_AW      = LAYER_AW + 1;
    localparam int MEM_DEPTH   = 1 << MEM_AW;

    // Q1.15 arithmetic constants
    localparam logic [15:0] Q_ONE       = 16'd32768;
    localparam logic [15:0] HALF_ONE    = 16'd16384;
    localparam logic [15:0] LIGHT_FLOOR = 16'd2621;
    localparam logic [16:0] D_SCALE     = 17'd108134;  // 3.3
    localparam logic [12:0] SIXTH       = 13'd5461;    // 1/6
    localparam logic [14:0] RND         = 15'd16384;   // half LSB before >> 15
    localparam int          F_BASE      = 13763;       // 0.42
    localparam int          F_SPAN      = 13107;       // 0.4

    // Pipeline layout
    localparam int QW         = 16;                    // attenuation quotient bits
    localparam int DIV_STEPS  = 2;                     // quotient bits per stage
    localparam int DIV_STAGES = QW / DIV_STEPS;
    localparam int ST_DIV0    = 5;
    localparam int ST_B       = ST_DIV0 + DIV_STAGES;
    localparam int ST_OUT     = ST_B + 1;
    localparam int NST        = ST_OUT + 1;

    // Sun offset per axis
    typedef enum logic [1:0] {
        OFS_ZERO,
        OFS_POS,
        OFS_NEG
    } t_ofs;

    // Height factor per layer
    typedef logic [GRID_Z-1:0][14:0] t_f_table;

    function automatic t_f_table f_table_init();
        t_f_table tbl;
        for (int i = 0; i < GRID_Z; i++) begin
            tbl[i] = 15'(F_BASE + (F_SPAN * i + GRID_Z / 2) / GRID_Z);
        end
        return tbl;
    endfunction

    localparam t_f_table F_TABLE = f_table_init();

    // Payload carried down the pipeline
    typedef struct packed {
        logic                top;
        logic                wbank;
        logic [LAYER_AW-1:0] idx;
        logic [ZW-1:0]       z;
        logic                last;
        logic [15:0]         plight;
        logic [16:0]         d;
        logic [15:0]         u;
        logic [17:0]         w;
        logic [18:0]         t;
        logic [15:0]         num_lo;
        logic [18:0]         rem;
        logic [QW-1:0]       quo;
        logic [15:0]         b;
        logic [15:0]         light;
    } t_stage;

endpackage

FILE: design/voxel_light_attenuation_core.sv
// Throughput: one cell per cycle within a layer while the master side does not stall; the attenuation
// divide is an 8-stage pipelined restoring divider at two quotient bits per stage. The first cell
// of a layer below the top waits for the layer above to write back its light.
// Reset (synchronous, active low) empties the pipeline, returns the position to the top
// layer and restores the default sun offset; the layer stores are not cleared.
module voxel_light_attenuation_core
    import vla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,   // sun_azimuth
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // [15:0] cloud_density
    input  logic        i_s_tuser,     // [0] grid_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,     // [15:0] light_level
    output logic        o_m_tlast
);

    // Sun offset decode from azimuth (Q3.13 radians)
    function automatic t_ofs ofs_x(input logic [15:0] v);
        t_ofs o;
        if (v >= 16'd51472) begin
            o = (v <= 16'd60789) ? OFS_POS : OFS_ZERO;
        end else if (v <= 16'd9317 || v >= 16'd42155) begin
            o = OFS_POS;
        end else if (v >= 16'd16419 && v <= 16'd35053) begin
            o = OFS_NEG;
        end else begin
            o = OFS_ZERO;
        end
        return o;
    endfunction

    function automatic t_ofs ofs_y(input logic [15:0] v);
        t_ofs o;
        if (v >= 16'd51472) begin
            o = (v >= 16'd55023) ? OFS_POS : OFS_ZERO;
        end else if (v >= 16'd3551 && v <= 16'd22185) begin
            o = OFS_POS;
        end else if (v >= 16'd29287 && v <= 16'd47921) begin
            o = OFS_NEG;
        end else begin
            o = OFS_ZERO;
        end
        return o;
    endfunction

    // Index step to the parent cell, modulo the index width
    function automatic logic [LAYER_AW-1:0] parent_step(input t_ofs dx, input t_ofs dy);
        logic [LAYER_AW-1:0] sx;
        logic [LAYER_AW-1:0] sy;
        unique case (dx)
            OFS_POS: sx = LAYER_AW'(1);
            OFS_NEG: sx = '1;
            default: sx = '0;
        endcase
        unique case (dy)
            OFS_POS: sy = LAYER_AW'(GRID_X);
            OFS_NEG: sy = ~LAYER_AW'(GRID_X) + LAYER_AW'(1);
            default: sy = '0;
        endcase
        return sx + sy;
    endfunction

    localparam logic [XW-1:0] XMAX = XW'(GRID_X - 1);
    localparam logic [YW-1:0] YMAX = YW'(GRID_Y - 1);
    localparam logic [ZW-1:0] ZMAX = ZW'(GRID_Z - 1);

    // Configuration and position state
    t_ofs                r_dx;
    t_ofs                r_dy;
    logic [LAYER_AW-1:0] r_pofs;
    logic [XW-1:0]       r_col;
    logic [YW-1:0]       r_row;
    logic [ZW-1:0]       r_lay;
    logic [LAYER_AW-1:0] r_idx;

    // Pipeline
    logic   [NST-1:0] r_vld;
    t_stage           r_st [NST];
    t_stage           n_st [NST];
    logic   [NST:0]   w_rdy;

    // Layer stores
    logic [15:0] r_light_mem [MEM_DEPTH];
    logic [15:0] r_dens_mem  [MEM_DEPTH];
    logic [15:0] r_rd_light;
    logic [15:0] r_rd_dens;

    logic [XW-1:0]       eff_col;
    logic [YW-1:0]       eff_row;
    logic [ZW-1:0]       eff_lay;
    logic [LAYER_AW-1:0] eff_idx;
    logic                eff_top;
    logic                wbank;
    logic                rbank;
    logic                x_ok;
    logic                y_ok;
    logic [LAYER_AW-1:0] pidx;
    logic                hazard;
    logic                s_accept;
    logic                light_we;

    // Position of the incoming cell
    assign eff_col = i_s_tuser ? '0   : r_col;
    assign eff_row = i_s_tuser ? '0   : r_row;
    assign eff_lay = i_s_tuser ? ZMAX : r_lay;
    assign eff_idx = i_s_tuser ? '0   : r_idx;
    assign eff_top = (eff_lay == ZMAX);
    assign wbank   = eff_lay[0];
    assign rbank   = ~eff_lay[0];

    // Parent cell, straight above when the offset leaves the grid
    assign x_ok = !((r_dx == OFS_POS && eff_col == XMAX) || (r_dx == OFS_NEG && eff_col == '0));
    assign y_ok = !((r_dy == OFS_POS && eff_row == YMAX) || (r_dy == OFS_NEG && eff_row == '0));
    assign pidx = (x_ok && y_ok) ? eff_idx + r_pofs : eff_idx;

    // Hold a cell whose parent layer still has light in flight
    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < ST_OUT; k++) begin
            if (r_vld[k] && r_st[k].wbank == rbank) begin
                hazard = 1'b1;
            end
        end
    end

    // Per-stage backpressure
    always_comb begin
        w_rdy[NST] = i_m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k + 1];
        end
    end

    assign o_s_tready = w_rdy[0] && !(hazard && !eff_top);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign light_we   = w_rdy[ST_OUT] && r_vld[ST_OUT-1];

    // Stage datapath
    always_comb begin
        logic [15:0] p;
        logic [32:0] sum_d;
        logic [30:0] sum_u;
        logic [33:0] sum_w;
        logic [35:0] sum_t;
        logic [30:0] num;
        logic [18:0] rem;
        logic [19:0] rem2;
        logic [15:0] lo;
        logic [QW-1:0] quo;
        logic [18:0] tv;
        logic [32:0] sum_b;
        logic [31:0] sum_l;
        logic [16:0] lt;
        int          bi;

        // Stage 0: position and flags of the accepted cell
        n_st[0]        = '0;
        n_st[0].top    = eff_top;
        n_st[0].wbank  = wbank;
        n_st[0].idx    = eff_idx;
        n_st[0].z      = eff_lay;
        n_st[0].last   = (eff_lay == '0) && (eff_row == YMAX) && (eff_col == XMAX);

        for (int k = 1; k < NST; k++) begin
            n_st[k] = r_st[k-1];
        end

        // Stage 1: saturate parent density, d = 3.3 p
        p     = (r_rd_dens > Q_ONE) ? Q_ONE : r_rd_dens;
        sum_d = 33'(p) * 33'(D_SCALE) + 33'(RND);
        n_st[1].plight = r_rd_light;
        n_st[1].d      = sum_d[31:15];

        // Stage 2: u = 0.5 + d/6
        sum_u = 31'(r_st[1].d) * 31'(SIXTH) + 31'(RND);
        n_st[2].u = HALF_ONE + sum_u[30:15];

        // Stage 3: w = 1 + d u
        sum_w = 34'(r_st[2].d) * 34'(r_st[2].u) + 34'(RND);
        n_st[3].w = 18'(Q_ONE) + 18'(sum_w >> 15);

        // Stage 4: t = 1 + d w
        sum_t = 36'(r_st[3].d) * 36'(r_st[3].w) + 36'(RND);
        n_st[4].t = 19'(Q_ONE) + 19'(sum_t >> 15);

        // Divider stages: att = (2^30 + t/2) / t, two quotient bits each
        for (int j = 0; j < DIV_STAGES; j++) begin
            tv = r_st[ST_DIV0+j-1].t;
            if (j == 0) begin
                num = 31'(32'h4000_0000) + 31'(tv >> 1);
                rem = 19'(num[30:16]);
                lo  = num[15:0];
                quo = '0;
            end else begin
                rem = r_st[ST_DIV0+j-1].rem;
                lo  = r_st[ST_DIV0+j-1].num_lo;
                quo = r_st[ST_DIV0+j-1].quo;
            end
            for (int s = 0; s < DIV_STEPS; s++) begin
                bi   = QW - 1 - j * DIV_STEPS - s;
                rem2 = {rem, lo[bi]};
                if (rem2 >= {1'b0, tv}) begin
                    rem     = 19'(rem2 - {1'b0, tv});
                    quo[bi] = 1'b1;
                end else begin
                    rem     = rem2[18:0];
                end
            end
            n_st[ST_DIV0+j].rem    = rem;
            n_st[ST_DIV0+j].num_lo = lo;
            n_st[ST_DIV0+j].quo    = quo;
        end

        // Attenuate parent light
        sum_b = 33'(r_st[ST_B-1].plight) * 33'(r_st[ST_B-1].quo) + 33'(RND);
        n_st[ST_B].b = sum_b[30:15];

        // Height factor, floor and top-layer full light
        sum_l = 32'(r_st[ST_OUT-1].b) * 32'(F_TABLE[r_st[ST_OUT-1].z]) + 32'(RND);
        lt    = sum_l[31:15];
        if (r_st[ST_OUT-1].top) begin
            n_st[ST_OUT].light = Q_ONE;
        end else if (lt < 17'(LIGHT_FLOOR)) begin
            n_st[ST_OUT].light = LIGHT_FLOOR;
        end else if (lt > 17'(Q_ONE)) begin
            n_st[ST_OUT].light = Q_ONE;
        end else begin
            n_st[ST_OUT].light = lt[15:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_dx   <= OFS_POS;
            r_dy   <= OFS_POS;
            r_pofs <= parent_step(OFS_POS, OFS_POS);
            r_col  <= '0;
            r_row  <= '0;
            r_lay  <= ZMAX;
            r_idx  <= '0;
        end else begin
            // Advance valid bits
            if (w_rdy[0]) begin
                r_vld[0] <= s_accept;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            // Take a new sun direction
            if (i_cfg_we) begin
                r_dx   <= ofs_x(i_cfg_wdata);
                r_dy   <= ofs_y(i_cfg_wdata);
                r_pofs <= parent_step(ofs_x(i_cfg_wdata), ofs_y(i_cfg_wdata));
            end
            // Step the grid position, wrap to the top layer after the last cell
            if (s_accept) begin
                if (eff_col == XMAX) begin
                    r_col <= '0;
                    if (eff_row == YMAX) begin
                        r_row <= '0;
                        r_idx <= '0;
                        r_lay <= (eff_lay == '0) ? ZMAX : eff_lay - ZW'(1);
                    end else begin
                        r_row <= eff_row + YW'(1);
                        r_idx <= eff_idx + LAYER_AW'(1);
                        r_lay <= eff_lay;
                    end
                end else begin
                    r_col <= eff_col + XW'(1);
                    r_row <= eff_row;
                    r_idx <= eff_idx + LAYER_AW'(1);
                    r_lay <= eff_lay;
                end
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (w_rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Layer stores: density written on accept, light written as it leaves the datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_dens_mem[{wbank, eff_idx}] <= i_s_tdata;
        end
        if (w_rdy[0]) begin
            r_rd_dens <= r_dens_mem[{rbank, pidx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (light_we) begin
            r_light_mem[{r_st[ST_OUT-1].wbank, r_st[ST_OUT-1].idx}] <= n_st[ST_OUT].light;
        end
        if (w_rdy[0]) begin
            r_rd_light <= r_light_mem[{rbank, pidx}];
        end
    end

    // Output register
    assign o_m_tvalid = r_vld[ST_OUT];
    assign o_m_tdata  = r_st[ST_OUT].light;
    assign o_m_tlast  = r_st[ST_OUT].last;

    // Checks
    a_no_bank_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (light_we && s_accept && !eff_top) |-> (r_st[ST_OUT-1].wbank != rbank))
        else $error("light write-back collides with a parent read");

    a_start_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser) |=> (r_vld[0] && r_st[0].top))
        else $error("grid start did not enter at the top layer");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= XMAX) && (r_row <= YMAX) && (r_lay <= ZMAX))
        else $error("grid position out of range");

    a_light_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata >= LIGHT_FLOOR && o_m_tdata <= Q_ONE))
        else $error("light level outside floor and full scale");

    a_top_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_st[ST_OUT].top) |-> (o_m_tdata == Q_ONE))
        else $error("top layer cell not at full light");

endmodule
